// ----- hdl/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/csh_pkg.sv -----
`default_nettype none
package csh_pkg;

   // one signed Q1.14 component and a three component vector
   typedef logic signed [15:0] comp_type;
   typedef comp_type [2:0] vec_type;

   // local frame carried down the pipeline
   typedef struct packed {
      vec_type tangent;
      vec_type bitangent;
      vec_type normal;
   } frame_type;

   // rotation datapath width
   localparam int CW = 34;
   localparam int MAX_STAGES = 24;

   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
   localparam logic signed [15:0] Q14_ONE = 16'sd16384;

   // arctan(2^-i) in Q30, truncated
   localparam logic signed [CW-1:0] ATAN_Q30 [MAX_STAGES] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
      34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
      34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
      34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
   };

   // saturate to [-1, 1] in Q1.14
   function automatic comp_type clamp_q14(input logic signed [23:0] v);
      comp_type r;
      if (v > 24'sd16384) begin
         r = Q14_ONE;
      end else if (v < -24'sd16384) begin
         r = -Q14_ONE;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/csh_cordic.sv -----
`default_nettype none
module csh_cordic #(
   parameter int STAGES = 16
) (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [30:0]                  angle,
   input  wire logic [1:0]                   quadrant,
   output logic signed [15:0]                cos_phi,
   output logic signed [15:0]                sin_phi
);

   localparam int CW = csh_pkg::CW;

   logic signed [CW-1:0] x_ff [STAGES];
   logic signed [CW-1:0] y_ff [STAGES];
   logic signed [CW-1:0] z_ff [STAGES];
   logic [1:0]           q_ff [STAGES];
   logic signed [15:0]   cos_ff, sin_ff;

   // one rotation per register stage
   for (genvar I = 0; I < STAGES; I++) begin : g_rot
      logic signed [CW-1:0] x_src, y_src, z_src;
      logic [1:0]           q_src;
      logic signed [CW-1:0] x_in, y_in, z_in;

      if (I == 0) begin : g_first
         assign x_src = csh_pkg::CORDIC_GAIN_Q30;
         assign y_src = '0;
         assign z_src = $signed({{(CW-31){1'b0}}, angle});
         assign q_src = quadrant;
      end else begin : g_next
         assign x_src = x_ff[I-1];
         assign y_src = y_ff[I-1];
         assign z_src = z_ff[I-1];
         assign q_src = q_ff[I-1];
      end

      always_comb begin
         if (!z_src[CW-1]) begin
            x_in = x_src - (y_src >>> I);
            y_in = y_src + (x_src >>> I);
            z_in = z_src - csh_pkg::ATAN_Q30[I];
         end else begin
            x_in = x_src + (y_src >>> I);
            y_in = y_src - (x_src >>> I);
            z_in = z_src + csh_pkg::ATAN_Q30[I];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[I] <= x_in;
            y_ff[I] <= y_in;
            z_ff[I] <= z_in;
            q_ff[I] <= q_src;
         end
      end
   end

   // quadrant fold and rounding to Q1.14
   logic signed [CW-1:0] c_raw, s_raw, c_rnd, s_rnd;
   logic signed [15:0]   cos_in, sin_in;

   always_comb begin
      unique case (q_ff[STAGES-1])
         2'd0: begin
            c_raw = x_ff[STAGES-1];
            s_raw = y_ff[STAGES-1];
         end
         2'd1: begin
            c_raw = -y_ff[STAGES-1];
            s_raw = x_ff[STAGES-1];
         end
         2'd2: begin
            c_raw = -x_ff[STAGES-1];
            s_raw = -y_ff[STAGES-1];
         end
         default: begin
            c_raw = y_ff[STAGES-1];
            s_raw = -x_ff[STAGES-1];
         end
      endcase
      c_rnd  = (c_raw + 34'sd32768) >>> 16;
      s_rnd  = (s_raw + 34'sd32768) >>> 16;
      cos_in = csh_pkg::clamp_q14(c_rnd[23:0]);
      sin_in = csh_pkg::clamp_q14(s_rnd[23:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_phi = cos_ff;
   assign sin_phi = sin_ff;

endmodule
`default_nettype wire

// ----- hdl/csh_sqrt.sv -----
`default_nettype none
module csh_sqrt #(
   parameter int STAGES = 16
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [16:0] radicand,
   output logic [14:0]      root
);

   localparam int MW = 2 * STAGES + 3;
   localparam int RW = STAGES + 1;

   logic [MW-1:0] rem_ff [STAGES];
   logic [RW-1:0] r_ff   [STAGES];
   logic [14:0]   root_ff;

   // one result bit per stage, most significant first
   for (genvar J = 0; J <= STAGES; J++) begin : g_bit
      localparam int B = STAGES - J;
      logic [MW-1:0] rem_src, delta, rem_in;
      logic [RW-1:0] r_src, r_in;

      if (J == 0) begin : g_first
         assign rem_src = MW'(radicand) << (2 * STAGES - 16);
         assign r_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[J-1];
         assign r_src   = r_ff[J-1];
      end

      // (r + 2^B)^2 - r^2
      always_comb begin
         delta = (MW'(r_src) << (B + 1)) + (MW'(1) << (2 * B));
         if (rem_src >= delta) begin
            rem_in = rem_src - delta;
            r_in   = r_src | (RW'(1) << B);
         end else begin
            rem_in = rem_src;
            r_in   = r_src;
         end
      end

      if (J < STAGES) begin : g_reg
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[J] <= rem_in;
               r_ff[J]   <= r_in;
            end
         end
      end else begin : g_out
         // bring the root to Q1.14
         logic [14:0] root_in;
         if (STAGES > 14) begin : g_round
            localparam int SH = STAGES - 14;
            logic [RW:0] rnd;
            assign rnd     = {1'b0, r_in} + ((RW + 1)'(1) << (SH - 1));
            assign root_in = 15'(rnd >> SH);
         end else if (STAGES < 14) begin : g_widen
            assign root_in = {r_in, {(14 - STAGES){1'b0}}};
         end else begin : g_exact
            assign root_in = r_in;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff <= root_in;
            end
         end
      end
   end

   assign root = root_ff;

endmodule
`default_nettype wire

// ----- hdl/csh_combine.sv -----
`default_nettype none
module csh_combine (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [15:0]  cos_phi,
   input  wire logic signed [15:0]  sin_phi,
   input  wire logic [14:0]         cos_elev,
   input  wire logic [14:0]         sin_elev,
   input  wire csh_pkg::frame_type  frame,
   output csh_pkg::vec_type         dir,
   output logic [14:0]              density
);

   logic signed [31:0] inner_ff [3];
   logic signed [31:0] nz_ff    [3];
   logic [14:0]        st_ff;
   logic [45:0]        dprod_ff;
   logic signed [47:0] sum_ff   [3];
   logic [14:0]        dens_ff, density_ff;
   csh_pkg::vec_type   dir_ff;

   logic signed [31:0] inner_in [3];
   logic signed [31:0] nz_in    [3];
   logic signed [47:0] sum_in   [3];
   logic signed [47:0] rnd      [3];
   csh_pkg::vec_type   dir_in;
   logic [45:0]        dprod_in, dround;

   // stage a: azimuth blend of tangent and bitangent, normal weight, density product
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         inner_in[k] = cos_phi * $signed(frame.tangent[k])
                     + sin_phi * $signed(frame.bitangent[k]);
         nz_in[k]    = $signed({1'b0, cos_elev}) * $signed(frame.normal[k]);
      end
      dprod_in = 46'(cos_elev) * 46'(csh_pkg::INV_PI_Q32);
   end

   // stage b: elevation weight and density rounding; stage c: round and saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = $signed({1'b0, st_ff}) * inner_ff[k] + (48'(nz_ff[k]) <<< 14);
         rnd[k]    = (sum_ff[k] + (48'sd1 <<< 27)) >>> 28;
         dir_in[k] = csh_pkg::clamp_q14(rnd[k][23:0]);
      end
      dround = (dprod_ff + (46'd1 << 29)) >> 30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inner_ff   <= inner_in;
         nz_ff      <= nz_in;
         st_ff      <= sin_elev;
         dprod_ff   <= dprod_in;
         sum_ff     <= sum_in;
         dens_ff    <= dround[14:0];
         dir_ff     <= dir_in;
         density_ff <= dens_ff;
      end
   end

   assign dir     = dir_ff;
   assign density = density_ff;

endmodule
`default_nettype wire

// ----- hdl/cosine_hemisphere_sampler.sv -----
`default_nettype none
// Cosine-weighted hemisphere sampler. Each transfer on req carries a local frame
// (tangent, bitangent, normal in Q1.14) and two Q0.16 uniform samples; rsp returns
// the sampled direction in Q1.14 and the density cos(theta)/pi in Q0.16. The block
// is a fully pipelined datapath that takes one item per cycle while rsp is not
// stalled. Each result passes through one input stage, APPROX_STAGES CORDIC rotation
// stages running beside the bit-per-stage square roots, one stage of quadrant fold
// and root rounding, and three stages of frame multiply, accumulate and saturation.
// A stall on rsp freezes the whole pipeline; nothing is dropped.
// APPROX_STAGES ranges from 8 to 24.
`include "assert_macros.svh"
module cosine_hemisphere_sampler #(
   parameter int APPROX_STAGES = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z,
   // normal_x, normal_y, normal_z, azimuth_sample, elevation_sample
   input  wire logic [175:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // dir_x, dir_y, dir_z, density, one zero fill bit
   output logic [63:0]        rsp_tdata
);

   localparam int LAT = APPROX_STAGES + 5;
   localparam int FD  = APPROX_STAGES + 2;

   logic en;
   logic [LAT-1:0] valid_ff, valid_in;

   csh_pkg::frame_type frame_ff [FD];
   logic [30:0] angle_ff;
   logic [1:0]  quad_ff;
   logic [16:0] vcos_ff, vsin_ff;

   csh_pkg::frame_type frame_req;
   logic [44:0] angle_prod;

   logic signed [15:0] cos_phi, sin_phi;
   logic [14:0] cos_elev, sin_elev;
   csh_pkg::vec_type dir;
   logic [14:0] density;
   logic dir_x_ok;

   // whole pipeline advances unless the output is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en && !reset;

   always_comb begin
      valid_in = {valid_ff[LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // unpack the request
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         frame_req.tangent[k]   = req_tdata[16*k +: 16];
         frame_req.bitangent[k] = req_tdata[48 + 16*k +: 16];
         frame_req.normal[k]    = req_tdata[96 + 16*k +: 16];
      end
      angle_prod = 45'(req_tdata[157:144]) * 45'(csh_pkg::PI_HALF_Q30);
   end

   // input stage: angle, quadrant and the two radicands
   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_prod[44:14];
         quad_ff  <= req_tdata[159:158];
         vsin_ff  <= {1'b0, req_tdata[175:160]};
         vcos_ff  <= 17'd65536 - {1'b0, req_tdata[175:160]};
      end
   end

   // frame rides along until the combine stage
   for (genvar F = 0; F < FD; F++) begin : g_frame
      always_ff @(posedge clock) begin
         if (en) begin
            if (F == 0) begin
               frame_ff[F] <= frame_req;
            end else begin
               frame_ff[F] <= frame_ff[(F == 0) ? 0 : F - 1];
            end
         end
      end
   end

   csh_cordic #(.STAGES(APPROX_STAGES)) u_cordic (
      .clock    (clock),
      .en       (en),
      .angle    (angle_ff),
      .quadrant (quad_ff),
      .cos_phi  (cos_phi),
      .sin_phi  (sin_phi)
   );

   csh_sqrt #(.STAGES(APPROX_STAGES)) u_sqrt_cos (
      .clock    (clock),
      .en       (en),
      .radicand (vcos_ff),
      .root     (cos_elev)
   );

   csh_sqrt #(.STAGES(APPROX_STAGES)) u_sqrt_sin (
      .clock    (clock),
      .en       (en),
      .radicand (vsin_ff),
      .root     (sin_elev)
   );

   csh_combine u_combine (
      .clock    (clock),
      .en       (en),
      .cos_phi  (cos_phi),
      .sin_phi  (sin_phi),
      .cos_elev (cos_elev),
      .sin_elev (sin_elev),
      .frame    (frame_ff[FD-1]),
      .dir      (dir),
      .density  (density)
   );

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {1'b0, density, dir[2], dir[1], dir[0]};

   // result ranges
   assign dir_x_ok = (dir[0] <= csh_pkg::Q14_ONE) && (dir[0] >= -csh_pkg::Q14_ONE);

   `ASSERT_IMPLIES(a_density_range, clock, reset, rsp_tvalid, density <= 15'd20861, "bad density")
   `ASSERT_IMPLIES(a_dir_x_range, clock, reset, rsp_tvalid, dir_x_ok, "dir_x out of range")
   `ASSERT_HOLDS(a_ready, clock, reset, req_tready == (!rsp_tvalid || rsp_tready), "bad ready")

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 5;
   localparam int WATCHDOG_LIMIT = 20000;

   // fixed-point arctangents of 2^-i, truncated Q30
   localparam longint ATAN_TAB [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
   };

   typedef struct packed {
      logic [15:0] elevation;
      logic [15:0] azimuth;
      logic [8:0][15:0] frame;   // tx,ty,tz,bx,by,bz,nx,ny,nz from low up
   } sample_req_type;

   typedef struct {
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [15:0] dir_z;
      logic [14:0] density;
   } direction_type;

   function automatic longint clamp_unit(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   // rotation-based sin/cos of a fraction of a turn, in Q1.14
   function automatic void turn_sincos(logic [15:0] az, output longint c, output longint s);
      longint x, y, z, dx, dy, cc, ss;
      x = 652032874; y = 0;
      z = (longint'(az[13:0]) * 1686629713) >>> 14;
      for (int i = 0; i < STAGES; i++) begin
         dx = asr(y, i); dy = asr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end
      end
      case (az[15:14])
         2'd0: begin cc = x; ss = y; end
         2'd1: begin cc = -y; ss = x; end
         2'd2: begin cc = -x; ss = -y; end
         default: begin cc = y; ss = -x; end
      endcase
      c = clamp_unit(asr(cc + 32768, 16));
      s = clamp_unit(asr(ss + 32768, 16));
   endfunction

   function automatic longint root_q14(longint v);
      longint m, r, t;
      m = v << (2 * STAGES - 16);
      r = 0;
      for (int b = STAGES; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= m) r = t;
      end
      if (STAGES > 14) r = (r + (64'd1 << (STAGES - 15))) >> (STAGES - 14);
      else if (STAGES < 14) r = r << (14 - STAGES);
      return r;
   endfunction

   function automatic direction_type sample_direction(sample_req_type q);
      direction_type d;
      longint cp, sp, ct, st, inner, sum, comp [3], dens;
      turn_sincos(q.azimuth, cp, sp);
      ct = root_q14(65536 - longint'(q.elevation));
      st = root_q14(longint'(q.elevation));
      for (int k = 0; k < 3; k++) begin
         inner = cp * longint'($signed(q.frame[k])) + sp * longint'($signed(q.frame[3+k]));
         sum = st * inner + ct * longint'($signed(q.frame[6+k])) * 16384;
         comp[k] = clamp_unit(asr(sum + (64'd1 << 27), 28));
      end
      dens = (ct * 4 * 1367130551 + 64'h80000000) >>> 32;
      d.dir_x = comp[0][15:0]; d.dir_y = comp[1][15:0]; d.dir_z = comp[2][15:0];
      d.density = dens[14:0];
      return d;
   endfunction

   class direction_board;
      direction_type pending [$];
      int mismatches = 0;

      function void note_request(sample_req_type q);
         pending.push_back(sample_direction(q));
      endfunction

      function void check_response(logic [63:0] data);
         direction_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", data);
            return;
         end
         e = pending.pop_front();
         if (data[15:0] !== e.dir_x || data[31:16] !== e.dir_y ||
             data[47:32] !== e.dir_z || data[62:48] !== e.density || data[63] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp x=%h y=%h z=%h d=%h got %h",
                        e.dir_x, e.dir_y, e.dir_z, e.density, data);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0;
   logic [175:0] req_tdata = '0;
   logic req_tready, rsp_tvalid;
   logic [63:0] rsp_tdata;
   direction_board board = new();
   int idle_cycles = 0;
   bit stall_mode = 0;

   always #4 clock = ~clock;

   cosine_hemisphere_sampler #(.APPROX_STAGES(STAGES)) DUT (.*);

   // receiver back-pressure: alternating stall and free-flow periods
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
   end

   // scoreboard and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic send_item(sample_req_type q);
      req_tvalid <= 1;
      req_tdata <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      sample_req_type q;
      int burst;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: axis, full-scale and alternating-sign frames, sample extremes, quadrant boundaries
      for (int i = 0; i < 24; i++) begin
         q = '0;
         q.frame[0] = 16'sd16384; q.frame[4] = 16'sd16384; q.frame[8] = 16'sd16384;
         if (i >= 12) for (int k = 0; k < 9; k++) q.frame[k] = (i & 1) ? 16'h8000 : 16'h7FFF;
         if (i >= 18) for (int k = 0; k < 9; k++) q.frame[k] = (k & 1) ? -16'sd16384 : 16'sd16384;
         case (i % 6)
            0: begin q.azimuth = 16'h0000; q.elevation = 16'h0000; end
            1: begin q.azimuth = 16'hFFFF; q.elevation = 16'hFFFF; end
            2: begin q.azimuth = 16'h4000; q.elevation = 16'h8000; end
            3: begin q.azimuth = 16'h8000; q.elevation = 16'h0001; end
            4: begin q.azimuth = 16'hC000; q.elevation = 16'hFFFE; end
            default: begin q.azimuth = 16'h3FFF; q.elevation = 16'h5555; end
         endcase
         send_item(q);
      end

      // hold until the pipeline has emptied
      drain();

      // random bursts
      for (int n = 0; n < 1200; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst; b++, n++) begin
            for (int k = 0; k < 9; k++) q.frame[k] = rand_comp();
            q.azimuth = 16'($urandom);
            q.elevation = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
            send_item(q);
         end
         if (n == 600) drain();
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
      drain();
      repeat (LATENCY + 5) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
